// ===== hw/rtl/fwsp_pkg.sv =====
// shared types, constants and saturation helpers for the four-wheel speed pid unit
// no dependencies
package fwsp_pkg;

    localparam int WHEELS    = 4;
    localparam int WIDX_W    = (WHEELS > 1) ? $clog2(WHEELS) : 1;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 6;

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(47);
    localparam logic [CNT_W-1:0] RDIV_LAST = CNT_W'(63);
    localparam logic [CNT_W-1:0] SDIV_LAST = CNT_W'(31);

    localparam logic signed [31:0] ITERM_MAX_RST   = 32'sd65536000;
    localparam logic signed [31:0] ITERM_MIN_RST   = -32'sd65536000;
    localparam logic [15:0]        DRIVE_LIMIT_RST = 16'd1000;
    localparam logic [30:0]        SPEED_MAX_RST   = 31'd20185088;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_ITERM_MAX   = 3'd3,
        CFG_ITERM_MIN   = 3'd4,
        CFG_DRIVE_LIMIT = 3'd5,
        CFG_SPEED_MAX   = 3'd6
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADDC,
        ST_CHECK,
        ST_RS_LD,
        ST_RS_MUL,
        ST_RS_DIV,
        ST_RS_WB,
        ST_SPD_LD,
        ST_SPD_DIV,
        ST_SPD_WB,
        ST_P_MUL,
        ST_P_WB,
        ST_I_MUL,
        ST_I_WB,
        ST_D_MUL,
        ST_D_WB,
        ST_FIN,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        r = v[31:0];
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        r = v[47:0];
        if (v[48] != v[47])
        begin
            r = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/four_wheel_speed_pid_unit.sv =====
// four-wheel speed pid unit: target load, rescale, speed measure and pid per wheel
// uses fwsp_pkg; one shift-add multiplier and one restoring divider under a sequencer
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  mode, target_a..d, count_a..d, elapsed_us,
//                                           heading_correction
// out       output     out_valid / out_stall drive_mag_a..d, drive_dir_a..d
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// a load item writes the targets; a tick runs per wheel a 32-step speed division
// (skipped when elapsed_us is zero) and three 48-step multiplications, plus a
// 48-step multiplication and a 64-step division per wheel when targets are rescaled
// reset clears the wheel targets, speeds, last counts, error sums and last errors and loads the register defaults
// a result waits in the output register; a new item is taken meanwhile, and the
// sequencer holds before its last step until the output register is free
module four_wheel_speed_pid_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic signed [31:0]                 target_a,
    input  logic signed [31:0]                 target_b,
    input  logic signed [31:0]                 target_c,
    input  logic signed [31:0]                 target_d,
    input  logic signed [15:0]                 count_a,
    input  logic signed [15:0]                 count_b,
    input  logic signed [15:0]                 count_c,
    input  logic signed [15:0]                 count_d,
    input  logic [15:0]                        elapsed_us,
    input  logic signed [31:0]                 heading_correction,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [15:0]                        drive_mag_a,
    output logic [15:0]                        drive_mag_b,
    output logic [15:0]                        drive_mag_c,
    output logic [15:0]                        drive_mag_d,
    output logic                               drive_dir_a,
    output logic                               drive_dir_b,
    output logic                               drive_dir_c,
    output logic                               drive_dir_d,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fwsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data
);
    import fwsp_pkg::*;

    state_t state_reg, state_next;

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] iterm_max_reg, iterm_min_reg;
    logic [15:0]        drive_limit_reg;
    logic [30:0]        speed_max_reg;

    logic signed [31:0] tgt_reg   [WHEELS];
    logic signed [31:0] tgt_next  [WHEELS];
    logic signed [31:0] meas_reg  [WHEELS];
    logic signed [31:0] meas_next [WHEELS];
    logic signed [15:0] lastc_reg [WHEELS];
    logic signed [15:0] lastc_next[WHEELS];
    logic signed [47:0] esum_reg  [WHEELS];
    logic signed [47:0] esum_next [WHEELS];
    logic signed [31:0] lerr_reg  [WHEELS];
    logic signed [31:0] lerr_next [WHEELS];
    logic [15:0]        wmag_reg  [WHEELS];
    logic [15:0]        wmag_next [WHEELS];
    logic               wdir_reg  [WHEELS];
    logic               wdir_next [WHEELS];
    logic [15:0]        omag_reg  [WHEELS];
    logic [15:0]        omag_next [WHEELS];
    logic               odir_reg  [WHEELS];
    logic               odir_next [WHEELS];
    logic signed [15:0] cnt_in_reg[WHEELS];
    logic signed [15:0] cnt_in_next[WHEELS];

    logic signed [31:0] in_tgt [WHEELS];
    logic signed [15:0] in_cnt [WHEELS];

    logic [15:0]        elapsed_reg, elapsed_next;
    logic signed [31:0] corr_reg, corr_next;
    logic [WIDX_W-1:0]  widx_reg, widx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [31:0]        largest_reg, largest_next;
    logic [79:0]        prod_reg, prod_next;
    logic [31:0]        mcand_reg, mcand_next;
    logic               neg_reg, neg_next;
    logic [63:0]        dsh_reg, dsh_next;
    logic [31:0]        drem_reg, drem_next;
    logic [31:0]        dvsr_reg, dvsr_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [47:0] pt_reg, pt_next;
    logic signed [31:0] it_reg, it_next;
    logic signed [48:0] dt_reg, dt_next;
    logic               out_valid_reg, out_valid_next;

    logic [32:0]        msum;
    logic [79:0]        mstep;
    logic [32:0]        dtry;
    logic               dge;
    logic [31:0]        drem_step;
    logic [63:0]        dsh_step;
    logic               last_wheel;

    logic signed [32:0] s33;
    logic [31:0]        abs32;
    logic signed [15:0] delta16;
    logic [15:0]        adelta;
    logic [31:0]        quo;
    logic signed [31:0] spd;
    logic signed [31:0] errv;
    logic signed [47:0] sumv;
    logic signed [47:0] m48s;
    logic signed [64:0] itv;
    logic signed [32:0] ddiff;
    logic [32:0]        addiff;
    logic signed [49:0] osum;
    logic signed [49:0] lim50;
    logic signed [49:0] oclp;
    logic [49:0]        oabs;
    logic [47:0]        esum_abs;

    assign in_tgt[0] = target_a;
    assign in_tgt[1] = target_b;
    assign in_tgt[2] = target_c;
    assign in_tgt[3] = target_d;
    assign in_cnt[0] = count_a;
    assign in_cnt[1] = count_b;
    assign in_cnt[2] = count_c;
    assign in_cnt[3] = count_d;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    assign drive_mag_a = omag_reg[0];
    assign drive_mag_b = omag_reg[1];
    assign drive_mag_c = omag_reg[2];
    assign drive_mag_d = omag_reg[3];
    assign drive_dir_a = odir_reg[0];
    assign drive_dir_b = odir_reg[1];
    assign drive_dir_c = odir_reg[2];
    assign drive_dir_d = odir_reg[3];

    // shared shift-add multiplier step
    assign msum  = {1'b0, prod_reg[79:48]} + (prod_reg[0] ? {1'b0, mcand_reg} : 33'd0);
    assign mstep = {msum, prod_reg[47:1]};

    // shared restoring divider step
    assign dtry      = {drem_reg, dsh_reg[63]};
    assign dge       = (dtry >= {1'b0, dvsr_reg});
    assign drem_step = dge ? 32'(dtry - {1'b0, dvsr_reg}) : dtry[31:0];
    assign dsh_step  = {dsh_reg[62:0], dge};

    assign last_wheel = (widx_reg == WIDX_W'(WHEELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            gain_p_reg      <= '0;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
            iterm_max_reg   <= ITERM_MAX_RST;
            iterm_min_reg   <= ITERM_MIN_RST;
            drive_limit_reg <= DRIVE_LIMIT_RST;
            speed_max_reg   <= SPEED_MAX_RST;
            out_valid_reg   <= 1'b0;
            widx_reg        <= '0;
            cnt_reg         <= '0;
            for (int i = 0; i < WHEELS; i++)
            begin
                tgt_reg[i]   <= '0;
                meas_reg[i]  <= '0;
                lastc_reg[i] <= '0;
                esum_reg[i]  <= '0;
                lerr_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            widx_reg      <= widx_next;
            cnt_reg       <= cnt_next;
            for (int i = 0; i < WHEELS; i++)
            begin
                tgt_reg[i]   <= tgt_next[i];
                meas_reg[i]  <= meas_next[i];
                lastc_reg[i] <= lastc_next[i];
                esum_reg[i]  <= esum_next[i];
                lerr_reg[i]  <= lerr_next[i];
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_GAIN_P:      gain_p_reg      <= cfg_data;
                    CFG_GAIN_I:      gain_i_reg      <= cfg_data;
                    CFG_GAIN_D:      gain_d_reg      <= cfg_data;
                    CFG_ITERM_MAX:   iterm_max_reg   <= cfg_data;
                    CFG_ITERM_MIN:   iterm_min_reg   <= cfg_data;
                    CFG_DRIVE_LIMIT: drive_limit_reg <= cfg_data[15:0];
                    CFG_SPEED_MAX:   speed_max_reg   <= cfg_data[30:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        corr_reg    <= corr_next;
        largest_reg <= largest_next;
        prod_reg    <= prod_next;
        mcand_reg   <= mcand_next;
        neg_reg     <= neg_next;
        dsh_reg     <= dsh_next;
        drem_reg    <= drem_next;
        dvsr_reg    <= dvsr_next;
        err_reg     <= err_next;
        pt_reg      <= pt_next;
        it_reg      <= it_next;
        dt_reg      <= dt_next;
        for (int i = 0; i < WHEELS; i++)
        begin
            wmag_reg[i]   <= wmag_next[i];
            wdir_reg[i]   <= wdir_next[i];
            omag_reg[i]   <= omag_next[i];
            odir_reg[i]   <= odir_next[i];
            cnt_in_reg[i] <= cnt_in_next[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        widx_next      = widx_reg;
        cnt_next       = cnt_reg;
        elapsed_next   = elapsed_reg;
        corr_next      = corr_reg;
        largest_next   = largest_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        neg_next       = neg_reg;
        dsh_next       = dsh_reg;
        drem_next      = drem_reg;
        dvsr_next      = dvsr_reg;
        err_next       = err_reg;
        pt_next        = pt_reg;
        it_next        = it_reg;
        dt_next        = dt_reg;
        for (int i = 0; i < WHEELS; i++)
        begin
            tgt_next[i]    = tgt_reg[i];
            meas_next[i]   = meas_reg[i];
            lastc_next[i]  = lastc_reg[i];
            esum_next[i]   = esum_reg[i];
            lerr_next[i]   = lerr_reg[i];
            wmag_next[i]   = wmag_reg[i];
            wdir_next[i]   = wdir_reg[i];
            omag_next[i]   = omag_reg[i];
            odir_next[i]   = odir_reg[i];
            cnt_in_next[i] = cnt_in_reg[i];
        end

        s33      = '0;
        abs32    = '0;
        delta16  = '0;
        adelta   = '0;
        quo      = dsh_reg[31:0];
        spd      = neg_reg ? -$signed(quo) : $signed(quo);
        errv     = '0;
        sumv     = '0;
        m48s     = '0;
        itv      = '0;
        ddiff    = '0;
        addiff   = '0;
        esum_abs = '0;
        lim50    = $signed({18'd0, drive_limit_reg, 16'd0});
        osum     = 50'(pt_reg) + 50'(it_reg) + 50'(dt_reg);
        oclp     = osum;
        oabs     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!mode)
                    begin
                        for (int i = 0; i < WHEELS; i++)
                        begin
                            tgt_next[i] = in_tgt[i];
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < WHEELS; i++)
                        begin
                            cnt_in_next[i] = in_cnt[i];
                        end
                        elapsed_next = elapsed_us;
                        corr_next    = heading_correction;
                        largest_next = '0;
                        widx_next    = '0;
                        state_next   = ST_ADDC;
                    end
                end
            end
            ST_ADDC:
            begin
                s33 = 33'(tgt_reg[widx_reg]) + 33'(corr_reg);
                tgt_next[widx_reg] = sat32(s33);
                abs32 = meas_reg[widx_reg][31] ? 32'(-meas_reg[widx_reg])
                                               : 32'(meas_reg[widx_reg]);
                if (abs32 > largest_reg)
                begin
                    largest_next = abs32;
                end
                widx_next = widx_reg + 1'b1;
                if (last_wheel)
                begin
                    widx_next  = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (largest_reg > {1'b0, speed_max_reg}) ? ST_RS_LD : ST_SPD_LD;
            end
            ST_RS_LD:
            begin
                abs32 = tgt_reg[widx_reg][31] ? 32'(-tgt_reg[widx_reg])
                                              : 32'(tgt_reg[widx_reg]);
                mcand_next = abs32;
                prod_next  = {32'd0, 17'd0, speed_max_reg};
                neg_next   = tgt_reg[widx_reg][31];
                cnt_next   = '0;
                state_next = ST_RS_MUL;
            end
            ST_RS_MUL:
            begin
                prod_next = mstep;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    dsh_next   = mstep[63:0];
                    drem_next  = '0;
                    dvsr_next  = largest_reg;
                    cnt_next   = '0;
                    state_next = ST_RS_DIV;
                end
            end
            ST_RS_DIV:
            begin
                dsh_next  = dsh_step;
                drem_next = drem_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == RDIV_LAST)
                begin
                    state_next = ST_RS_WB;
                end
            end
            ST_RS_WB:
            begin
                tgt_next[widx_reg] = spd;
                widx_next = widx_reg + 1'b1;
                state_next = ST_RS_LD;
                if (last_wheel)
                begin
                    widx_next  = '0;
                    state_next = ST_SPD_LD;
                end
            end
            ST_SPD_LD:
            begin
                delta16 = cnt_in_reg[widx_reg] - lastc_reg[widx_reg];
                adelta  = delta16[15] ? 16'(-delta16) : 16'(delta16);
                lastc_next[widx_reg] = cnt_in_reg[widx_reg];
                drem_next = '0;
                dvsr_next = {16'd0, elapsed_reg};
                cnt_next  = '0;
                if (elapsed_reg == 16'd0)
                begin
                    dsh_next   = '0;
                    neg_next   = 1'b0;
                    state_next = ST_SPD_WB;
                end
                else
                begin
                    dsh_next   = {adelta, 48'd0};
                    neg_next   = delta16[15];
                    state_next = ST_SPD_DIV;
                end
            end
            ST_SPD_DIV:
            begin
                dsh_next  = dsh_step;
                drem_next = drem_step;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == SDIV_LAST)
                begin
                    state_next = ST_SPD_WB;
                end
            end
            ST_SPD_WB:
            begin
                meas_next[widx_reg] = spd;
                s33  = 33'(tgt_reg[widx_reg]) - 33'(spd);
                errv = sat32(s33);
                err_next = errv;
                sumv = sat48(49'(esum_reg[widx_reg]) + 49'(errv));
                esum_next[widx_reg] = sumv;
                abs32 = errv[31] ? 32'(-errv) : 32'(errv);
                mcand_next = gain_p_reg[31] ? 32'(-gain_p_reg) : 32'(gain_p_reg);
                prod_next  = {32'd0, 16'd0, abs32};
                neg_next   = gain_p_reg[31] ^ errv[31];
                cnt_next   = '0;
                state_next = ST_P_MUL;
            end
            ST_P_MUL, ST_I_MUL, ST_D_MUL:
            begin
                prod_next = mstep;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    unique case (state_reg)
                        ST_P_MUL: state_next = ST_P_WB;
                        ST_I_MUL: state_next = ST_I_WB;
                        default:  state_next = ST_D_WB;
                    endcase
                end
            end
            ST_P_WB:
            begin
                m48s    = $signed(prod_reg[63:16]);
                pt_next = neg_reg ? -m48s : m48s;
                esum_abs = esum_reg[widx_reg][47] ? 48'(-esum_reg[widx_reg])
                                                  : 48'(esum_reg[widx_reg]);
                mcand_next = gain_i_reg[31] ? 32'(-gain_i_reg) : 32'(gain_i_reg);
                prod_next  = {32'd0, esum_abs};
                neg_next   = gain_i_reg[31] ^ esum_reg[widx_reg][47];
                cnt_next   = '0;
                state_next = ST_I_MUL;
            end
            ST_I_WB:
            begin
                itv = neg_reg ? -$signed({1'b0, prod_reg[79:16]})
                              : $signed({1'b0, prod_reg[79:16]});
                priority if (itv > 65'(iterm_max_reg))
                begin
                    it_next = iterm_max_reg;
                end
                else if (itv < 65'(iterm_min_reg))
                begin
                    it_next = iterm_min_reg;
                end
                else
                begin
                    it_next = itv[31:0];
                end
                ddiff  = 33'(err_reg) - 33'(lerr_reg[widx_reg]);
                addiff = ddiff[32] ? 33'(-ddiff) : 33'(ddiff);
                lerr_next[widx_reg] = err_reg;
                mcand_next = gain_d_reg[31] ? 32'(-gain_d_reg) : 32'(gain_d_reg);
                prod_next  = {32'd0, 15'd0, addiff};
                neg_next   = gain_d_reg[31] ^ ddiff[32];
                cnt_next   = '0;
                state_next = ST_D_MUL;
            end
            ST_D_WB:
            begin
                dt_next = neg_reg ? -$signed({1'b0, prod_reg[63:16]})
                                  : $signed({1'b0, prod_reg[63:16]});
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                priority if (osum > lim50)
                begin
                    oclp = lim50;
                end
                else if (osum < -lim50)
                begin
                    oclp = -lim50;
                end
                else
                begin
                    oclp = osum;
                end
                oabs = oclp[49] ? 50'(-oclp) : 50'(oclp);
                wmag_next[widx_reg] = oabs[31:16];
                wdir_next[widx_reg] = !(oclp > 50'sd0);
                widx_next  = widx_reg + 1'b1;
                state_next = ST_SPD_LD;
                if (last_wheel)
                begin
                    widx_next  = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    for (int i = 0; i < WHEELS; i++)
                    begin
                        omag_next[i] = wmag_reg[i];
                        odir_next[i] = wdir_reg[i];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode) |=> (state_reg == ST_ADDC))
        else $error("tick did not start the sequence");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !(out_valid_reg && out_stall))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not presented");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_valid_reg && out_stall) |=> (state_reg == ST_OUT))
        else $error("result overwritten while stalled");

    a_spd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPD_DIV) |-> (cnt_reg <= SDIV_LAST))
        else $error("speed division ran past its last step");

    a_largest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RS_DIV) |-> (dvsr_reg != 32'd0))
        else $error("rescale division by zero");

endmodule
